### design/lpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and codes for the length-prefixed deframer: queue entry layout,
// queue operation codes, result kind codes and the heartbeat pattern.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HB_LEN    = 9;
  localparam int unsigned BURST_W   = HB_LEN * BYTE_W;
  localparam int unsigned MAXLEN_W  = 25;
  localparam int unsigned LENGTH_W  = 32;
  localparam int unsigned BEAT_W    = 4;

  // Operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_ECHO  = 2'd0,
    OP_HB    = 2'd1,
    OP_ERR   = 2'd2,
    OP_BURST = 2'd3
  } lpd_op_t;

  // Result kind codes as seen on the output
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_HB   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Input command codes
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Byte k of the pattern sits at bits [8k+7:8k]
  localparam logic [BURST_W-1:0] HB_PATTERN = {
    8'h74, 8'h61, 8'h65, 8'h62, 8'h74, 8'h72, 8'h61, 8'h65, 8'h68
  };

  localparam logic [BEAT_W-1:0] BURST_LAST_BEAT = BEAT_W'(HB_LEN - 1);

  typedef struct packed {
    lpd_op_t              op;
    logic                 last;
    logic [BURST_W-1:0]   data;
  } lpd_entry_t;

endpackage

### design/lpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_front
// Accepts one item per cycle, tracks header and payload phases, holds the
// first bytes of a nine-byte payload and pushes one entry per result event.
// ----------------------------------------------------------------------------
module lpd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               command,
  input  logic [lpd_pkg::BYTE_W-1:0]         data_byte,
  input  logic                               cfg_we,
  input  logic [lpd_pkg::MAXLEN_W-1:0]       max_payload_length,
  output logic                               push,
  output lpd_pkg::lpd_entry_t                entry
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;

  logic [1:0]                        phase;
  logic [1:0]                        header_count;
  logic [lpd_pkg::LENGTH_W-1:0]      length_value;
  logic [lpd_pkg::MAXLEN_W-1:0]      payload_left;
  logic [lpd_pkg::MAXLEN_W-1:0]      max_len;
  logic [lpd_pkg::BYTE_W-1:0]        hold_bytes [8];

  logic [lpd_pkg::LENGTH_W-1:0]      len_shift;
  logic                              bad_len;
  logic [lpd_pkg::MAXLEN_W-1:0]      left_dec;
  logic [3:0]                        hold_idx;
  logic                              is_nine;
  logic [lpd_pkg::BURST_W-1:0]       burst;
  logic                              data_in;

  assign data_in   = accept && (command == lpd_pkg::CMD_DATA);
  assign len_shift = {length_value[lpd_pkg::LENGTH_W-lpd_pkg::BYTE_W-1:0], data_byte};
  assign bad_len   = (len_shift == '0) ||
                     (len_shift > {{(lpd_pkg::LENGTH_W-lpd_pkg::MAXLEN_W){1'b0}}, max_len});
  assign left_dec  = payload_left - 1'b1;
  assign hold_idx  = 4'(4'd9 - payload_left[3:0]);
  assign is_nine   = (length_value == lpd_pkg::LENGTH_W'(lpd_pkg::HB_LEN));
  assign burst     = {data_byte, hold_bytes[7], hold_bytes[6], hold_bytes[5],
                      hold_bytes[4], hold_bytes[3], hold_bytes[2], hold_bytes[1],
                      hold_bytes[0]};

  always_comb begin
    push       = 1'b0;
    entry.op   = lpd_pkg::OP_ECHO;
    entry.last = 1'b1;
    entry.data = '0;
    if (data_in) begin
      unique case (phase)
        PH_CLOSED: begin
        end
        PH_PAYLOAD: begin
          if (is_nine) begin
            if (payload_left <= lpd_pkg::MAXLEN_W'(1)) begin
              push = 1'b1;
              if (burst == lpd_pkg::HB_PATTERN) begin
                entry.op = lpd_pkg::OP_HB;
              end else begin
                entry.op   = lpd_pkg::OP_BURST;
                entry.data = burst;
              end
            end
          end else begin
            push       = 1'b1;
            entry.op   = lpd_pkg::OP_ECHO;
            entry.last = (left_dec == '0);
            entry.data = lpd_pkg::BURST_W'(data_byte);
          end
        end
        default: begin
          if (header_count == 2'd3 && bad_len) begin
            push     = 1'b1;
            entry.op = lpd_pkg::OP_ERR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lpd_pkg::MAXLEN_W'(65536);
    end else if (cfg_we) begin
      max_len <= max_payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      length_value <= '0;
      payload_left <= '0;
    end else if (accept && command == lpd_pkg::CMD_CLEAR) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      length_value <= '0;
      payload_left <= '0;
    end else if (data_in) begin
      unique case (phase)
        PH_CLOSED: begin
        end
        PH_PAYLOAD: begin
          if (is_nine && payload_left > lpd_pkg::MAXLEN_W'(1)) begin
            payload_left <= left_dec;
          end else if (is_nine || left_dec == '0) begin
            // frame done, back to header
            payload_left <= '0;
            phase        <= PH_HEADER;
            length_value <= '0;
          end else begin
            payload_left <= left_dec;
          end
        end
        default: begin
          length_value <= len_shift;
          if (header_count != 2'd3) begin
            header_count <= header_count + 2'd1;
          end else begin
            header_count <= '0;
            if (bad_len) begin
              phase        <= PH_CLOSED;
              payload_left <= '0;
            end else begin
              phase        <= PH_PAYLOAD;
              payload_left <= len_shift[lpd_pkg::MAXLEN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Capture the first eight bytes of a nine-byte payload
  always_ff @(posedge clk) begin
    if (data_in && phase == PH_PAYLOAD && is_nine &&
        payload_left > lpd_pkg::MAXLEN_W'(1) && !hold_idx[3]) begin
      hold_bytes[hold_idx[2:0]] <= data_byte;
    end
  end

endmodule

### design/lpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_queue
// Small first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module lpd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lpd_pkg::lpd_entry_t  push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output lpd_pkg::lpd_entry_t  head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_pkg::lpd_entry_t  slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/lpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_back
// Drains queue entries into the output register, one result per cycle while
// out_stall is low, stepping through the nine bytes of a held-back burst.
// ----------------------------------------------------------------------------
module lpd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  lpd_pkg::lpd_entry_t          q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [lpd_pkg::BYTE_W-1:0]   payload_byte,
  output logic                         last
);

  logic [lpd_pkg::BEAT_W-1:0]  beat;
  logic                        load;
  logic                        burst_mid;
  logic [lpd_pkg::BYTE_W-1:0]  burst_byte;

  assign load       = q_not_empty && (!out_valid || !out_stall);
  assign burst_mid  = (q_head.op == lpd_pkg::OP_BURST) && (beat != lpd_pkg::BURST_LAST_BEAT);
  assign q_pop      = load && !burst_mid;
  assign burst_byte = q_head.data[beat * lpd_pkg::BYTE_W +: lpd_pkg::BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        beat <= burst_mid ? beat + 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (q_head.op)
        lpd_pkg::OP_ECHO: begin
          kind         <= lpd_pkg::KIND_ECHO;
          payload_byte <= q_head.data[lpd_pkg::BYTE_W-1:0];
          last         <= q_head.last;
        end
        lpd_pkg::OP_BURST: begin
          kind         <= lpd_pkg::KIND_ECHO;
          payload_byte <= burst_byte;
          last         <= !burst_mid;
        end
        lpd_pkg::OP_HB: begin
          kind         <= lpd_pkg::KIND_HB;
          payload_byte <= '0;
          last         <= 1'b1;
        end
        default: begin
          kind         <= lpd_pkg::KIND_ERR;
          payload_byte <= '0;
          last         <= 1'b1;
        end
      endcase
    end
  end

endmodule

### design/length_prefixed_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Splits a byte stream into 4-byte big-endian length headers and payloads,
// echoes payload bytes, reports heartbeat frames and bad lengths.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  in       | in_valid / in_stall         | command, data_byte
//  out      | out_valid / out_stall       | kind, payload_byte, last
//  cfg      | cfg_we                      | max_payload_length
//
//  One input item per cycle while in_stall is low; the front finishes each byte
//  in its accept cycle. Results leave the output register one per cycle while
//  out_stall is low, so a nine-byte non-heartbeat frame gives nine results; the
//  entry queue absorbs that. Each result is queued, then registered at the output.
//  in_stall rises only when the entry queue is full (out_stall backs it up).
//  rst is synchronous; it clears state and sets the limit to 65536.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [lpd_pkg::BYTE_W-1:0]         data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         kind,
  output logic [lpd_pkg::BYTE_W-1:0]         payload_byte,
  output logic                               last,
  input  logic                               cfg_we,
  input  logic [lpd_pkg::MAXLEN_W-1:0]       max_payload_length
);

  logic                 accept;
  logic                 push;
  lpd_pkg::lpd_entry_t  push_entry;
  logic                 pop;
  logic                 q_full;
  logic                 q_not_empty;
  lpd_pkg::lpd_entry_t  q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  lpd_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .command            (command),
    .data_byte          (data_byte),
    .cfg_we             (cfg_we),
    .max_payload_length (max_payload_length),
    .push               (push),
    .entry              (push_entry)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  lpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last)
  );

endmodule

### design/lpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         kind,
  input  logic [lpd_pkg::BYTE_W-1:0]         payload_byte,
  input  logic                               last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) &&
      $stable(payload_byte) && $stable(last))
    else $error("stalled result changed");

  // Heartbeat and error results are single, closed and carry no byte
  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != lpd_pkg::KIND_ECHO |-> last && payload_byte == '0)
    else $error("event result malformed");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == lpd_pkg::KIND_ECHO || kind == lpd_pkg::KIND_HB ||
      kind == lpd_pkg::KIND_ERR)
    else $error("undefined result kind");

  // Reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind length_prefixed_deframer_top lpd_checker u_lpd_checker (.*);

### tb/tb_length_prefixed_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_deframer_top
// Self-checking bench for the length-prefixed deframer. A short table of
// directed items runs first. Random framed traffic follows under several
// length limits: good frames, heartbeat look-alikes, bad lengths and cut-off
// frames. A local model predicts each result unless a directed row gives it,
// and each result taken from the block is compared against the oldest one.
// ----------------------------------------------------------------------------
module tb_length_prefixed_deframer_top;
  import lpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned PHASE_ITEMS  = 5;
  localparam int unsigned N_DIRECTED   = 29;
  localparam int unsigned N_LIMITS     = 7;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;

  typedef enum logic [1:0] {
    CHK_PRED = 2'd0,  // result comes from the model
    CHK_NONE = 2'd1,  // no result
    CHK_ONE  = 2'd2   // one result, given in the row
  } chk_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        lst;
  } deframed_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  b;
    chk_t        chk;
    deframed_t   res;
  } stim_row_t;

  localparam deframed_t NO_RES  = '{KIND_ECHO, 8'h00, 1'b0};
  localparam deframed_t ERR_RES = '{KIND_ERR, 8'h00, 1'b1};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  command;
  logic [BYTE_W-1:0]     data_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            kind;
  logic [BYTE_W-1:0]     payload_byte;
  logic                  last;
  logic                  cfg_we;
  logic [MAXLEN_W-1:0]   max_payload_length;

  // model state
  logic [1:0]            dfr_phase = PH_HEADER;
  logic [1:0]            hdr_count = '0;
  logic [LENGTH_W-1:0]   frame_len = '0;
  logic [MAXLEN_W-1:0]   bytes_left = '0;
  logic [7:0]            held [0:7] = '{default: 8'h00};
  logic [MAXLEN_W-1:0]   len_limit = 25'd65536;

  deframed_t             deframed_q [$];
  int                    mismatches = 0;
  int                    cycle_count = 0;
  int                    items_sent = 0;
  bit                    hold_req = 1'b0;
  bit                    source_quiet = 1'b0;
  bit                    sink_quiet = 1'b0;
  bit                    offering = 1'b0;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    // one-byte frame
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h01, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'hFF, CHK_ONE,  '{KIND_ECHO, 8'hFF, 1'b1}},
    // heartbeat frame
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h09, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h68, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h65, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h61, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h72, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h74, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h62, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h65, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h61, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h74, CHK_ONE,  '{KIND_HB, 8'h00, 1'b1}},
    // zero length closes the stream, then a dropped byte and a clear
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_ONE,  ERR_RES},
    '{CMD_DATA,  8'h55, CHK_NONE, NO_RES},
    '{CMD_CLEAR, 8'hAA, CHK_NONE, NO_RES},
    // one above the reset limit
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h01, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h00, CHK_NONE, NO_RES},
    '{CMD_DATA,  8'h01, CHK_ONE,  ERR_RES},
    '{CMD_CLEAR, 8'h00, CHK_NONE, NO_RES}
  };

  length_prefixed_deframer_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .command            (command),
    .data_byte          (data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .payload_byte       (payload_byte),
    .last               (last),
    .cfg_we             (cfg_we),
    .max_payload_length (max_payload_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Advance the deframer model by one item; nres tells how many results it queued.
  task automatic deframe_step(input logic cmd, input logic [7:0] b, output int nres);
    logic [3:0] slot;
    logic       hb_match;
    int         k;
    nres = 0;
    if (cmd == CMD_CLEAR) begin
      dfr_phase  = PH_HEADER;
      hdr_count  = '0;
      frame_len  = '0;
      bytes_left = '0;
    end else if (dfr_phase == PH_CLOSED) begin
      nres = 0;
    end else if (dfr_phase != PH_PAYLOAD) begin
      frame_len = {frame_len[23:0], b};
      if (hdr_count < 2'd3) begin
        hdr_count = hdr_count + 2'd1;
      end else begin
        hdr_count = '0;
        if (frame_len == '0 || frame_len > {7'd0, len_limit}) begin
          dfr_phase  = PH_CLOSED;
          bytes_left = '0;
          deframed_q.push_back(ERR_RES);
          nres = 1;
        end else begin
          bytes_left = frame_len[MAXLEN_W-1:0];
          dfr_phase  = PH_PAYLOAD;
        end
      end
    end else if (frame_len == HB_LEN) begin
      // nine-byte payload: hold the first eight, decide on the ninth
      slot = 4'(HB_LEN - bytes_left);
      if (bytes_left > 1) begin
        if (slot < 4'd8) held[slot[2:0]] = b;
        bytes_left = bytes_left - 1'b1;
      end else begin
        bytes_left = '0;
        dfr_phase  = PH_HEADER;
        frame_len  = '0;
        hb_match   = (b == HB_PATTERN[8*8 +: 8]);
        for (k = 0; k < 8; k++)
          if (held[k] != HB_PATTERN[8*k +: 8]) hb_match = 1'b0;
        if (hb_match) begin
          deframed_q.push_back('{KIND_HB, 8'h00, 1'b1});
          nres = 1;
        end else begin
          for (k = 0; k < 8; k++) deframed_q.push_back('{KIND_ECHO, held[k], 1'b0});
          deframed_q.push_back('{KIND_ECHO, b, 1'b1});
          nres = HB_LEN;
        end
      end
    end else begin
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0) begin
        dfr_phase = PH_HEADER;
        frame_len = '0;
        deframed_q.push_back('{KIND_ECHO, b, 1'b1});
      end else begin
        deframed_q.push_back('{KIND_ECHO, b, 1'b0});
      end
      nres = 1;
    end
  endtask

  // Offer one item, wait for it to be taken, then draw the gap to the next one.
  task automatic send_item(input stim_row_t r);
    int nres;
    int gap;
    in_valid  <= 1'b1;
    command   <= r.cmd;
    data_byte <= r.b;
    offering   = 1'b1;
    do @(posedge clk); while (in_stall);
    if (!(r.cmd == CMD_DATA && dfr_phase == PH_CLOSED)) items_sent++;
    deframe_step(r.cmd, r.b, nres);
    if (r.chk != CHK_PRED) begin
      repeat (nres) void'(deframed_q.pop_back());
      if (r.chk == CHK_ONE) deframed_q.push_back(r.res);
    end
    @(negedge clk);
    gap = source_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    stim_row_t r;
    r     = '{CMD_DATA, 8'h00, CHK_PRED, NO_RES};
    r.b   = b;
    send_item(r);
  endtask

  task automatic send_clear();
    stim_row_t r;
    r     = '{CMD_CLEAR, 8'h00, CHK_PRED, NO_RES};
    r.b   = 8'($urandom_range(0, 255));
    send_item(r);
  endtask

  task automatic send_header(input logic [31:0] len);
    int k;
    for (k = 3; k >= 0; k--) send_byte(len[8*k +: 8]);
  endtask

  // Nine-byte payloads are the heartbeat, a near miss, or random bytes.
  task automatic send_payload(input logic [31:0] len);
    logic [7:0] b;
    logic [7:0] flip;
    int         k;
    int         mode;
    int         pos;
    mode = $urandom_range(0, 2);
    pos  = $urandom_range(0, HB_LEN - 1);
    flip = 8'($urandom_range(1, 255));
    for (k = 0; k < len; k++) begin
      if (len == HB_LEN && mode != 2) begin
        b = HB_PATTERN[8*k +: 8];
        if (mode == 1 && k == pos) b = b ^ flip;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
  endtask

  // Drop up to two bytes into the closed stream, then reopen it.
  task automatic close_stream();
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    send_clear();
  endtask

  task automatic drain_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    do @(negedge clk); while (deframed_q.size() != 0);
  endtask

  task automatic write_limit(input logic [MAXLEN_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we             <= 1'b1;
    max_payload_length <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_limit  = v;
  endtask

  // Result sink: random stall per item, one long hold on request.
  initial begin : result_sink
    int w;
    int taken;
    taken     = 0;
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        w        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        w = sink_quiet ? 0 : $urandom_range(0, 14);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
      taken++;
      if (taken % 20 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin : result_check
    deframed_t want;
    if (!rst && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h last %0b",
                   kind, payload_byte, last);
      end else begin
        want = deframed_q.pop_front();
        if (kind !== want.kind || payload_byte !== want.pbyte || last !== want.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                     want.kind, want.pbyte, want.lst, kind, payload_byte, last);
        end
      end
    end
  end

  initial begin : stimulus
    logic [MAXLEN_W-1:0] limits [0:N_LIMITS-1];
    logic [MAXLEN_W-1:0] lim;
    logic [31:0]         len;
    int                  i;
    int                  ph;
    int                  start;
    int                  pick;
    int                  n;
    limits = '{25'd16, 25'd9, 25'd1, 25'd0, 25'h1FF_FFFF, 25'd16777216, 25'd12};
    rst                = 1'b1;
    in_valid           = 1'b0;
    command            = CMD_DATA;
    data_byte          = '0;
    cfg_we             = 1'b0;
    max_payload_length = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) send_item(directed_rows[i]);

    for (ph = 0; ph < N_LIMITS; ph++) begin
      lim = (ph == N_LIMITS - 1) ? 25'($urandom_range(2, 12)) : limits[ph];
      write_limit(lim);
      if (ph == 1) begin
        // hold the output for a long time while multi-byte echo frames pile up
        hold_req     = 1'b1;
        source_quiet = 1'b1;
        repeat (4) begin
          len = $urandom_range(2, HB_LEN - 1);
          send_header(len);
          send_payload(len);
        end
        drain_results();
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        source_quiet = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          if (lim == 0) len = $urandom_range(1, 12);
          else if (lim >= HB_LEN && $urandom_range(0, 2) == 0) len = HB_LEN;
          else len = $urandom_range(1, (lim < 12) ? lim : 12);
          send_header(len);
          if (len > lim) close_stream();
          else send_payload(len);
        end else if (pick < 70) begin
          case ($urandom_range(0, 2))
            0: len = '0;
            1: len = {7'd0, lim} + 32'd1;
            default: len = $urandom | 32'h8000_0000;
          endcase
          send_header(len);
          close_stream();
        end else if (pick < 82) begin
          // cut a frame short, then reopen
          if (lim == 0 || $urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
          end else begin
            len = $urandom_range(1, (lim < 12) ? lim : 12);
            send_header(len);
            n = $urandom_range(0, len - 1);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
          end
          send_clear();
        end else if (pick < 92) begin
          send_clear();
        end else begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
design/lpd_pkg.sv
design/lpd_front.sv
design/lpd_queue.sv
design/lpd_back.sv
design/length_prefixed_deframer_top.sv
design/lpd_checker.sv
tb/tb_length_prefixed_deframer_top.sv
